// File: rtl/lptc_pkg.sv
// shared types, constants and helpers for the lead point tracking controller
`default_nettype none
package lptc_pkg;

	// quarter-wave sine polynomial coefficients, Q30
	localparam logic [30:0] TrigA = 31'd1686629713;
	localparam logic [29:0] TrigB = 30'd688904866;
	localparam logic [26:0] TrigC = 27'd76016977;

	// config register indexes
	localparam int unsigned CfgIdxW = 2;
	typedef enum logic [CfgIdxW-1:0] {
		CFG_INV_LAMBDA_RATE   = 2'd0,
		CFG_INV_LEAD_DISTANCE = 2'd1
	} cfg_idx_t;

	localparam logic [31:0] InvReset = 32'd65536;

	// pipeline depth from start to result strobe
	localparam int unsigned Latency = 8;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        heading;
		logic signed [31:0] ref_x;
		logic signed [31:0] ref_y;
		logic signed [31:0] ref_dx;
		logic signed [31:0] ref_dy;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] speed_cmd;
		logic signed [31:0] turn_cmd;
	} res_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
		logic signed [69:0] hi_lim;
		logic signed [69:0] lo_lim;
		hi_lim = 70'sd2147483647;
		lo_lim = -70'sd2147483648;
		if (v > hi_lim) begin
			sat32 = 32'sh7fffffff;
		end else if (v < lo_lim) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/lptc_sincos.sv
// four-stage pipelined sine of a 16-bit angle, signed Q1.16 result
`default_nettype none
module lptc_sincos (
	input  wire logic               clk,
	input  wire logic [15:0]        angle,
	output logic signed [17:0]      sin_val
);
	import lptc_pkg::*;

	logic [14:0] u_c;
	logic [29:0] uu_c;
	logic [14:0] u_s1, u_s2, u_s3;
	logic [14:0] z2_s1, z2_s2;
	logic        neg_s1, neg_s2, neg_s3;
	logic [41:0] t1_c;
	logic [29:0] p_s2;
	logic [44:0] t2_c;
	logic [30:0] q_s3;
	logic [45:0] s_c;
	logic [32:0] rnd_c;
	logic [16:0] mag_c;

	// fold angle into the first quarter and square it
	always_comb begin
		if (angle[14]) begin
			u_c = 15'd16384 - {1'b0, angle[13:0]};
		end else begin
			u_c = {1'b0, angle[13:0]};
		end
		uu_c = 30'(u_c) * 30'(u_c);
	end

	// polynomial steps, one multiply each
	assign t1_c  = 42'(TrigC) * 42'(z2_s1);
	assign t2_c  = 45'(p_s2) * 45'(z2_s2);
	assign s_c   = 46'(q_s3) * 46'(u_s3);
	assign rnd_c = 33'(s_c[45:14]) + 33'd8192;
	assign mag_c = rnd_c[30:14];

	always_ff @(posedge clk) begin
		u_s1    <= u_c;
		z2_s1   <= uu_c[28:14];
		neg_s1  <= angle[15];
		u_s2    <= u_s1;
		z2_s2   <= z2_s1;
		neg_s2  <= neg_s1;
		p_s2    <= TrigB - t1_c[41:14];
		u_s3    <= u_s2;
		neg_s3  <= neg_s2;
		q_s3    <= TrigA - t2_c[44:14];
		sin_val <= neg_s3 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
	end

endmodule
`default_nettype wire

// File: rtl/lead_point_tracking_control.sv
// lead point tracking controller top level
`default_nettype none
// Lead point tracking controller: one pose and reference sample per cycle in,
// speed and turn commands out of the last stage on res with res_valid high for
// one cycle. busy never rises, since the eight-stage pipeline (sine/cosine
// polynomial, error vector, projections, turn scaling) takes a new sample
// every cycle. The result cannot be held off by the receiver. Config writes
// are taken at once and should be made while no sample is in flight.
module lead_point_tracking_control (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire lptc_pkg::cmd_t                cmd,
	output lptc_pkg::res_t                     res,
	output logic                               res_valid,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lptc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [31:0]                   cfg_data
);
	import lptc_pkg::*;

	localparam logic signed [48:0] WLimit = 49'sd140737488355327;

	logic [31:0] inv_lambda_q;
	logic [31:0] inv_lead_q;
	logic [Latency-1:0] vld_q;

	logic        accept;
	logic [15:0] cos_angle;
	logic signed [17:0] sin_v, cos_v;

	logic signed [33:0] negd_x_c, negd_y_c;
	logic signed [63:0] der_x_c, der_y_c;
	logic signed [32:0] half_x_s1, half_y_s1;
	logic signed [63:0] der_x_s1, der_y_s1;
	logic signed [48:0] wsum_x_c, wsum_y_c;
	logic signed [47:0] wx_s2, wy_s2, wx_s3, wy_s3, wx_s4, wy_s4;
	logic signed [65:0] pcx_s5, psy_s5, psx_s5, pcy_s5;
	logic signed [66:0] nsx_c;
	logic signed [50:0] speed_sum_c;
	logic signed [51:0] normal_c;
	logic signed [31:0] speed_s6, speed_s7;
	logic signed [51:0] normal_s6;
	logic signed [68:0] phi_s7, plo_s7;
	logic        zero_s7, sat_s7, neg_s7;
	logic signed [69:0] turn_sum_c;
	res_t        res_s8;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign res       = res_s8;
	assign res_valid = vld_q[Latency-1];

	// config register transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_lambda_q <= InvReset;
			inv_lead_q   <= InvReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_INV_LAMBDA_RATE:   inv_lambda_q <= cfg_data;
				CFG_INV_LEAD_DISTANCE: inv_lead_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[Latency-2:0], accept};
		end
	end

	// sine and cosine pipelines, stages 1 to 4
	assign cos_angle = cmd.heading + 16'd16384;

	lptc_sincos u_sin (
		.clk     (clk),
		.angle   (cmd.heading),
		.sin_val (sin_v)
	);

	lptc_sincos u_cos (
		.clk     (clk),
		.angle   (cos_angle),
		.sin_val (cos_v)
	);

	// stage 1: half error and derivative products
	assign negd_x_c = 34'sd0 - (34'(cmd.pos_x) - 34'(cmd.ref_x));
	assign negd_y_c = 34'sd0 - (34'(cmd.pos_y) - 34'(cmd.ref_y));
	assign der_x_c  = cmd.ref_dx * $signed({1'b0, inv_lambda_q});
	assign der_y_c  = cmd.ref_dy * $signed({1'b0, inv_lambda_q});

	// stage 2: correction vector with clamp
	assign wsum_x_c = 49'(half_x_s1) + 49'($signed(der_x_s1[63:16]));
	assign wsum_y_c = 49'(half_y_s1) + 49'($signed(der_y_s1[63:16]));

	// stage 6: projections floored and summed
	assign nsx_c       = 67'sd0 - 67'(psx_s5);
	assign speed_sum_c = 51'($signed(pcx_s5[65:16])) + 51'($signed(psy_s5[65:16]));
	assign normal_c    = 52'($signed(nsx_c[66:16])) + 52'($signed(pcy_s5[65:16]));

	// stage 8: turn scaling sum
	assign turn_sum_c = 70'(phi_s7) + 70'($signed(plo_s7[68:16]));

	always_ff @(posedge clk) begin
		half_x_s1 <= negd_x_c[33:1];
		half_y_s1 <= negd_y_c[33:1];
		der_x_s1  <= der_x_c;
		der_y_s1  <= der_y_c;

		if (wsum_x_c > WLimit) begin
			wx_s2 <= WLimit[47:0];
		end else if (wsum_x_c < -WLimit) begin
			wx_s2 <= -WLimit[47:0];
		end else begin
			wx_s2 <= wsum_x_c[47:0];
		end
		if (wsum_y_c > WLimit) begin
			wy_s2 <= WLimit[47:0];
		end else if (wsum_y_c < -WLimit) begin
			wy_s2 <= -WLimit[47:0];
		end else begin
			wy_s2 <= wsum_y_c[47:0];
		end

		wx_s3 <= wx_s2;
		wy_s3 <= wy_s2;
		wx_s4 <= wx_s3;
		wy_s4 <= wy_s3;

		// stage 5: projection products
		pcx_s5 <= cos_v * wx_s4;
		psy_s5 <= sin_v * wy_s4;
		psx_s5 <= sin_v * wx_s4;
		pcy_s5 <= cos_v * wy_s4;

		speed_s6  <= sat32(70'(speed_sum_c));
		normal_s6 <= normal_c;

		// stage 7: turn scaling products and range flags
		speed_s7 <= speed_s6;
		phi_s7   <= normal_s6 * $signed({1'b0, inv_lead_q[31:16]});
		plo_s7   <= normal_s6 * $signed({1'b0, inv_lead_q[15:0]});
		zero_s7  <= (inv_lead_q == 32'd0);
		neg_s7   <= normal_s6[51];
		sat_s7   <= (normal_s6 >= 52'sh800000000000) || (normal_s6 <= -52'sh800000000000)
			|| ((inv_lead_q[31:16] != 16'd0)
			&& ((normal_s6 >= 52'sh100000000) || (normal_s6 <= -52'sh100000000)));

		res_s8.speed_cmd <= speed_s7;
		if (zero_s7) begin
			res_s8.turn_cmd <= 32'sd0;
		end else if (sat_s7) begin
			res_s8.turn_cmd <= neg_s7 ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			res_s8.turn_cmd <= sat32(turn_sum_c);
		end
	end

endmodule
`default_nettype wire

// File: rtl/lptc_checker.sv
// port-level checker for the lead point tracking controller, with its bind
`default_nettype none
module lptc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic res_valid,
	input wire logic cfg_ready
);
	import lptc_pkg::*;

	// every result comes from an earlier sample transfer through the pipeline
	a_res_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(start, Latency))
		else $error("result without matching sample transfer");

	// the pipeline never refuses a sample
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// config writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind lead_point_tracking_control lptc_checker u_lptc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.res_valid (res_valid),
	.cfg_ready (cfg_ready)
);
`default_nettype wire

// File: dv/tb.sv
// self-checking testbench for the lead point tracking controller
`timescale 1ns / 1ps
module tb;
	import lptc_pkg::*;

	localparam longint unsigned QuarterA = 64'd1686629713;
	localparam longint unsigned QuarterB = 64'd688904866;
	localparam longint unsigned QuarterC = 64'd76016977;
	localparam logic signed [95:0] WLimit = 96'sd140737488355327;
	localparam logic signed [31:0] S32Max = 32'sh7fffffff;
	localparam logic signed [31:0] S32Min = 32'sh80000000;
	localparam int ItemsPerPhase = 150;

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t r;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	cmd_t                cmd;
	res_t                res;
	logic                res_valid;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [31:0]         cfg_data;

	// model copy of the config registers
	logic [31:0] lambda_shadow;
	logic [31:0] lead_shadow;
	// directed rows carry a hand-read result next to the command
	logic        typed_now;
	res_t        typed_res;

	res_t        cmds_expected_q[$];
	int          errors;
	stim_row_t   stim_table[$];

	lead_point_tracking_control DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.res       (res),
		.res_valid (res_valid),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#4ms;
		$display("CHECK FAILED");
		$finish;
	end

	// quarter-wave polynomial, Q16 result
	function automatic longint quarter_wave(longint unsigned u);
		longint unsigned z2, t, p, q, s;
		z2 = (u * u) >> 14;
		t = (QuarterC * z2) >> 14;
		p = QuarterB - t;
		t = (p * z2) >> 14;
		q = QuarterA - t;
		s = (q * u) >> 14;
		return longint'((s + 64'd8192) >> 14);
	endfunction

	function automatic longint sine_q16(logic [15:0] h);
		longint m;
		m = h[14] ? quarter_wave(64'd16384 - h[13:0]) : quarter_wave(64'(h[13:0]));
		return h[15] ? -m : m;
	endfunction

	function automatic logic signed [31:0] clamp_q16(logic signed [95:0] v);
		if (v > 96'sd2147483647) return S32Max;
		if (v < -96'sd2147483648) return S32Min;
		return v[31:0];
	endfunction

	// speed and turn commands for one pose sample
	function automatic res_t predict_cmds(cmd_t c, logic [31:0] lam, logic [31:0] lead);
		logic signed [95:0] px, py, rx, ry, dx, dy, sn, cs, lamw, leadw;
		logic signed [95:0] wx, wy, normal;
		res_t r;
		px = c.pos_x; py = c.pos_y;
		rx = c.ref_x; ry = c.ref_y;
		dx = c.ref_dx; dy = c.ref_dy;
		sn = sine_q16(c.heading);
		cs = sine_q16(c.heading + 16'd16384);
		lamw = $signed({64'b0, lam});
		leadw = $signed({64'b0, lead});
		wx = ((-(px - rx)) >>> 1) + ((dx * lamw) >>> 16);
		wy = ((-(py - ry)) >>> 1) + ((dy * lamw) >>> 16);
		// intermediate limit on the correction vector
		if (wx > WLimit) wx = WLimit;
		if (wx < -WLimit) wx = -WLimit;
		if (wy > WLimit) wy = WLimit;
		if (wy < -WLimit) wy = -WLimit;
		r.speed_cmd = clamp_q16(((cs * wx) >>> 16) + ((sn * wy) >>> 16));
		normal = ((-(sn * wx)) >>> 16) + ((cs * wy) >>> 16);
		r.turn_cmd = clamp_q16((normal * leadw) >>> 16);
		return r;
	endfunction

	// register writes, input transfers and result checks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_shadow <= InvReset;
			lead_shadow <= InvReset;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_INV_LAMBDA_RATE: lambda_shadow <= cfg_data;
					CFG_INV_LEAD_DISTANCE: lead_shadow <= cfg_data;
					default: ;
				endcase
			end
			if (res_valid) begin
				if (cmds_expected_q.size() == 0) begin
					$error("unexpected result speed_cmd=%0d turn_cmd=%0d",
						res.speed_cmd, res.turn_cmd);
					errors++;
				end else begin
					res_t e;
					e = cmds_expected_q.pop_front();
					if (res.speed_cmd !== e.speed_cmd) begin
						$error("speed_cmd expected %0d actual %0d", e.speed_cmd, res.speed_cmd);
						errors++;
					end
					if (res.turn_cmd !== e.turn_cmd) begin
						$error("turn_cmd expected %0d actual %0d", e.turn_cmd, res.turn_cmd);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				if (typed_now) cmds_expected_q.push_back(typed_res);
				else cmds_expected_q.push_back(predict_cmds(cmd, lambda_shadow, lead_shadow));
			end
		end
	end

	task automatic add_row(int px, int py, int h, int rx, int ry, int dx, int dy,
			bit typed, int sp, int tn);
		stim_row_t row;
		row.c.pos_x = px; row.c.pos_y = py; row.c.heading = h[15:0];
		row.c.ref_x = rx; row.c.ref_y = ry;
		row.c.ref_dx = dx; row.c.ref_dy = dy;
		row.typed = typed;
		row.r.speed_cmd = sp; row.r.turn_cmd = tn;
		stim_table.push_back(row);
	endtask

	// one command transfer, then maybe an idle burst
	task automatic send_cmd(cmd_t c, bit typed, res_t r, bit may_idle);
		cmd <= c;
		typed_now <= typed;
		typed_res <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// stop sending and let the pipeline empty
	task automatic drain();
		start <= 1'b0;
		while (cmds_expected_q.size() != 0) @(posedge clk);
		repeat (Latency + 2) @(posedge clk);
	endtask

	task automatic set_config(logic [31:0] lam, logic [31:0] lead);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_INV_LAMBDA_RATE;
		cfg_data <= lam;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_INV_LEAD_DISTANCE;
		cfg_data <= lead;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_field();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
			2: return 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27);
			3: begin
				case ($urandom_range(0, 3))
					0: return S32Min;
					1: return S32Max;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
		endcase
	endfunction

	function automatic logic [15:0] rand_heading();
		if ($urandom_range(0, 4) == 0)
			return 16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 2)) - 16'd1;
		return 16'($urandom());
	endfunction

	initial begin
		logic [31:0] lam_set[6];
		logic [31:0] lead_set[6];
		cmd_t c;
		res_t none;
		errors = 0;
		none = '0;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		typed_now <= 1'b0;
		typed_res <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_INV_LAMBDA_RATE;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings
		add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		add_row(0, 0, 0, 0, 0, 65536, 0, 1, 65536, 0);
		add_row(0, 0, 16384, 0, 0, 0, 65536, 1, 65536, 0);
		add_row(0, 0, 16384, 0, 0, 65536, 0, 1, 0, -65536);
		add_row(0, 0, 32768, 0, 0, 65536, 0, 1, -65536, 0);
		add_row(131072, 0, 0, 0, 0, 0, 0, 1, -65536, 0);
		// output saturation both ways
		add_row(S32Min, 0, 0, S32Max, 0, S32Max, 0, 1, S32Max, 0);
		add_row(S32Max, 0, 0, S32Min, 0, S32Min, 0, 1, S32Min, 0);
		add_row(0, S32Max, 0, 0, S32Min, S32Min, 0, 0, 0, 0);
		add_row(0, S32Max, 0, 0, S32Min, 0, S32Min, 1, 0, S32Min);
		add_row(S32Max, S32Max, 16'hffff, S32Max, S32Max, S32Max, S32Max, 0, 0, 0);
		add_row(S32Min, S32Min, 16'h3fff, S32Min, S32Min, S32Min, S32Min, 0, 0, 0);
		add_row(-1, 1, 16'h4001, 1, -1, -1, -1, 0, 0, 0);
		add_row(S32Min, S32Max, 16'h8001, S32Max, S32Min, S32Max, S32Min, 0, 0, 0);
		add_row(12345678, -9876543, 16'hc000, -555555, 777777, 98765, -43210, 0, 0, 0);
		add_row(65536, 65536, 16'h2000, 0, 0, 32768, -32768, 0, 0, 0);
		add_row(-65536, 65536, 16'hbfff, 3, -3, 1, -1, 0, 0, 0);
		add_row(S32Max, S32Min, 16'h6000, 0, 0, S32Max, S32Max, 0, 0, 0);
		foreach (stim_table[i])
			send_cmd(stim_table[i].c, stim_table[i].typed, stim_table[i].r, 1'b1);
		drain();

		// random part over several register settings
		lam_set = '{32'd65536, 32'd0, 32'hffffffff, 32'd1, $urandom(), 32'h00008000};
		lead_set = '{32'd65536, 32'd0, 32'hffffffff, 32'd1, $urandom(), 32'h00030000};
		for (int p = 0; p < 6; p++) begin
			set_config(lam_set[p], lead_set[p]);
			for (int n = 0; n < ItemsPerPhase; n++) begin
				c.pos_x = rand_field(); c.pos_y = rand_field();
				c.heading = rand_heading();
				c.ref_x = rand_field(); c.ref_y = rand_field();
				c.ref_dx = rand_field(); c.ref_dy = rand_field();
				send_cmd(c, 1'b0, none, p != 5);
				// hold off until the pipeline is empty
				if (p == 2 && n == ItemsPerPhase / 2) drain();
			end
			drain();
		end

		if (errors == 0 && cmds_expected_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
